// ===== src/wav_riff_header_parser_assert.svh =====
// Assertion macros used by the port-level checker of the WAV header parser.
// Depends on nothing; included by wrp_checker.sv.
`ifndef WAV_RIFF_HEADER_PARSER_ASSERT_SVH
`define WAV_RIFF_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define WRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wav header parser: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define WRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wav header parser: next-cycle check failed");

`endif

// ===== src/wrp_pkg.sv =====
// Shared types and constants of the WAV header parser.
// Used by the front end, the request queue, the back end and the checker.
package wrp_pkg;

    // Parser phases.
    localparam logic [2:0] PH_RIFF  = 3'd0;
    localparam logic [2:0] PH_RSIZE = 3'd1;
    localparam logic [2:0] PH_WAVE  = 3'd2;
    localparam logic [2:0] PH_CID   = 3'd3;
    localparam logic [2:0] PH_CSIZE = 3'd4;
    localparam logic [2:0] PH_FMT   = 3'd5;
    localparam logic [2:0] PH_DATA  = 3'd6;
    localparam logic [2:0] PH_SKIP  = 3'd7;

    // Four-character tags as they arrive, first character in the top byte.
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_MIN  = 32'd16;
    localparam logic [15:0] PCM_TAG  = 16'd1;
    localparam logic [15:0] PCM_BITS = 16'd16;

    // Summary status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
    localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
    localparam logic [2:0] ST_FMT_SHORT = 3'd3;
    localparam logic [2:0] ST_NOT_PCM   = 3'd4;
    localparam logic [2:0] ST_NOT_16BIT = 3'd5;
    localparam logic [2:0] ST_NO_DATA   = 3'd6;

    // Result kinds.
    localparam logic RK_SAMPLE  = 1'b0;
    localparam logic RK_SUMMARY = 1'b1;

    // One request from the front end: a sample byte, a summary, or both.
    typedef struct packed {
        logic        has_sample;
        logic [7:0]  sample_byte;
        logic        chunk_first;
        logic        has_summary;
        logic [2:0]  status;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] data_bytes;
    } t_cmd;

endpackage

// ===== src/wrp_cmd_queue.sv =====
// Short request queue between the parser front end and the result back end.
// Depends on wrp_pkg for the request type.
module wrp_cmd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wrp_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output wrp_pkg::t_cmd o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wrp_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Storage is written at the tail only.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/wrp_front.sv =====
// Parser front end: walks the RIFF structure one byte per cycle while the queue has room and issues requests.
// Depends on wrp_pkg for phase codes, tags, status codes and the request type.
module wrp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_of_file,
    input  logic          i_queue_full,
    output logic          o_in_ready,
    output logic          o_push,
    output wrp_pkg::t_cmd o_cmd
);
    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_size, n_size;
    logic [63:0] r_fmt_lo, n_fmt_lo;
    logic [63:0] r_fmt_hi, n_fmt_hi;
    logic [2:0]  r_err, n_err;
    logic [31:0] r_dsize, n_dsize;

    logic        w_accept;
    logic        w_sample;
    logic        w_first;
    logic [31:0] w_cnt_inc;
    logic [2:0]  w_status;

    assign o_in_ready = !i_queue_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cnt_inc  = r_cnt + 32'd1;

    // Next state for the byte on the input.
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_tag    = r_tag;
        n_size   = r_size;
        n_fmt_lo = r_fmt_lo;
        n_fmt_hi = r_fmt_hi;
        n_err    = r_err;
        n_dsize  = r_dsize;
        w_sample = 1'b0;
        w_first  = 1'b0;
        if (r_err == wrp_pkg::ST_OK) begin
            case (r_phase)
                wrp_pkg::PH_RIFF, wrp_pkg::PH_WAVE, wrp_pkg::PH_CID: begin
                    n_tag = {r_tag[23:0], i_in_byte};
                    n_cnt = w_cnt_inc;
                    if (r_cnt[1:0] == 2'd3) begin
                        n_cnt = '0;
                        if (r_phase == wrp_pkg::PH_RIFF) begin
                            if (n_tag != wrp_pkg::TAG_RIFF) begin
                                n_err = wrp_pkg::ST_NOT_RIFF;
                            end else begin
                                n_phase = wrp_pkg::PH_RSIZE;
                            end
                        end else if (r_phase == wrp_pkg::PH_WAVE) begin
                            if (n_tag != wrp_pkg::TAG_WAVE) begin
                                n_err = wrp_pkg::ST_NOT_WAVE;
                            end else begin
                                n_phase = wrp_pkg::PH_CID;
                            end
                        end else begin
                            n_size  = '0;
                            n_phase = wrp_pkg::PH_CSIZE;
                        end
                    end
                end
                wrp_pkg::PH_RSIZE: begin
                    n_cnt = w_cnt_inc;
                    if (r_cnt[1:0] == 2'd3) begin
                        n_cnt   = '0;
                        n_phase = wrp_pkg::PH_WAVE;
                    end
                end
                wrp_pkg::PH_CSIZE: begin
                    // Size is little-endian; it was cleared when the id completed.
                    n_size[{r_cnt[1:0], 3'b000} +: 8] = i_in_byte;
                    n_cnt = w_cnt_inc;
                    if (r_cnt[1:0] == 2'd3) begin
                        n_cnt = '0;
                        if (r_tag == wrp_pkg::TAG_FMT) begin
                            if (n_size < wrp_pkg::FMT_MIN) begin
                                n_err = wrp_pkg::ST_FMT_SHORT;
                            end else begin
                                n_phase = wrp_pkg::PH_FMT;
                            end
                        end else if (r_tag == wrp_pkg::TAG_DATA) begin
                            n_dsize = n_size;
                            n_phase = (n_size != '0) ? wrp_pkg::PH_DATA : wrp_pkg::PH_CID;
                        end else begin
                            n_phase = (n_size != '0) ? wrp_pkg::PH_SKIP : wrp_pkg::PH_CID;
                        end
                    end
                end
                default: begin
                    // Chunk body: fmt capture, data pass-through or skip.
                    if (r_phase == wrp_pkg::PH_FMT && r_cnt[31:4] == '0) begin
                        if (!r_cnt[3]) begin
                            n_fmt_lo[{r_cnt[2:0], 3'b000} +: 8] = i_in_byte;
                        end else begin
                            n_fmt_hi[{r_cnt[2:0], 3'b000} +: 8] = i_in_byte;
                        end
                    end
                    if (r_phase == wrp_pkg::PH_DATA) begin
                        w_sample = 1'b1;
                        w_first  = (r_cnt == '0);
                    end
                    if (w_cnt_inc == r_size) begin
                        n_cnt   = '0;
                        n_phase = wrp_pkg::PH_CID;
                    end else begin
                        n_cnt = w_cnt_inc;
                    end
                end
            endcase
        end
    end

    // Summary status, judged on the state after this byte.
    always_comb begin
        if (n_err != wrp_pkg::ST_OK) begin
            w_status = n_err;
        end else if (n_phase == wrp_pkg::PH_RIFF) begin
            w_status = wrp_pkg::ST_NOT_RIFF;
        end else if (n_phase == wrp_pkg::PH_RSIZE || n_phase == wrp_pkg::PH_WAVE) begin
            w_status = wrp_pkg::ST_NOT_WAVE;
        end else if (n_fmt_lo[15:0] != wrp_pkg::PCM_TAG) begin
            w_status = wrp_pkg::ST_NOT_PCM;
        end else if (n_fmt_hi[63:48] != wrp_pkg::PCM_BITS) begin
            w_status = wrp_pkg::ST_NOT_16BIT;
        end else if (n_dsize == '0) begin
            w_status = wrp_pkg::ST_NO_DATA;
        end else begin
            w_status = wrp_pkg::ST_OK;
        end
    end

    // Request towards the back end.
    assign o_push                = w_accept && (w_sample || i_end_of_file);
    assign o_cmd.has_sample      = w_sample;
    assign o_cmd.sample_byte     = i_in_byte;
    assign o_cmd.chunk_first     = w_first;
    assign o_cmd.has_summary     = i_end_of_file;
    assign o_cmd.status          = w_status;
    assign o_cmd.channels        = n_fmt_lo[31:16];
    assign o_cmd.sample_rate     = n_fmt_lo[63:32];
    assign o_cmd.byte_rate       = n_fmt_hi[31:0];
    assign o_cmd.block_align     = n_fmt_hi[47:32];
    assign o_cmd.bits_per_sample = n_fmt_hi[63:48];
    assign o_cmd.data_bytes      = n_dsize;

    // Parser state; the end of a file returns it to the reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_end_of_file)) begin
            r_phase  <= wrp_pkg::PH_RIFF;
            r_cnt    <= '0;
            r_tag    <= '0;
            r_size   <= '0;
            r_fmt_lo <= '0;
            r_fmt_hi <= '0;
            r_err    <= wrp_pkg::ST_OK;
            r_dsize  <= '0;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_tag    <= n_tag;
            r_size   <= n_size;
            r_fmt_lo <= n_fmt_lo;
            r_fmt_hi <= n_fmt_hi;
            r_err    <= n_err;
            r_dsize  <= n_dsize;
        end
    end

endmodule

// ===== src/wrp_back.sv =====
// Result back end: expands queued requests into result items in an output register.
// Depends on wrp_pkg for the request type and result kinds.
module wrp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  wrp_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic          o_result_kind,
    output logic [7:0]    o_sample_byte,
    output logic          o_chunk_first,
    output logic [2:0]    o_status,
    output logic [15:0]   o_channels,
    output logic [31:0]   o_sample_rate,
    output logic [31:0]   o_byte_rate,
    output logic [15:0]   o_block_align,
    output logic [15:0]   o_bits_per_sample,
    output logic [31:0]   o_data_bytes,
    output logic          o_last
);
    logic        r_valid;
    logic        r_half;
    logic        r_kind;
    logic [7:0]  r_byte;
    logic        r_first;
    logic [2:0]  r_status;
    logic [15:0] r_channels;
    logic [31:0] r_rate;
    logic [31:0] r_byte_rate;
    logic [15:0] r_align;
    logic [15:0] r_bits;
    logic [31:0] r_dbytes;

    logic w_load;
    logic w_emit_sample;

    // The register is refilled whenever it is empty or being taken and the queue holds a request.
    assign w_load        = !i_empty && (!r_valid || i_out_ready);
    assign w_emit_sample = i_cmd.has_sample && !r_half;
    assign o_pop         = w_load && !(w_emit_sample && i_cmd.has_summary);

    // Control: output valid and the second-half flag of a two-result request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_half  <= w_emit_sample && i_cmd.has_summary;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload: a sample carries zeros in the summary fields and the other way round.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_emit_sample) begin
                r_kind      <= wrp_pkg::RK_SAMPLE;
                r_byte      <= i_cmd.sample_byte;
                r_first     <= i_cmd.chunk_first;
                r_status    <= wrp_pkg::ST_OK;
                r_channels  <= '0;
                r_rate      <= '0;
                r_byte_rate <= '0;
                r_align     <= '0;
                r_bits      <= '0;
                r_dbytes    <= '0;
            end else begin
                r_kind      <= wrp_pkg::RK_SUMMARY;
                r_byte      <= '0;
                r_first     <= 1'b0;
                r_status    <= i_cmd.status;
                r_channels  <= i_cmd.channels;
                r_rate      <= i_cmd.sample_rate;
                r_byte_rate <= i_cmd.byte_rate;
                r_align     <= i_cmd.block_align;
                r_bits      <= i_cmd.bits_per_sample;
                r_dbytes    <= i_cmd.data_bytes;
            end
        end
    end

    assign o_out_valid       = r_valid;
    assign o_result_kind     = r_kind;
    assign o_sample_byte     = r_byte;
    assign o_chunk_first     = r_first;
    assign o_status          = r_status;
    assign o_channels        = r_channels;
    assign o_sample_rate     = r_rate;
    assign o_byte_rate       = r_byte_rate;
    assign o_block_align     = r_align;
    assign o_bits_per_sample = r_bits;
    assign o_data_bytes      = r_dbytes;
    assign o_last            = (r_kind == wrp_pkg::RK_SUMMARY);

endmodule

// ===== src/wav_riff_header_parser.sv =====
// Top level of the WAV header parser; joins front end, request queue and back end.
// Depends on wrp_pkg, wrp_front, wrp_cmd_queue and wrp_back.
//
// The parser takes one file byte per cycle, checks the RIFF and WAVE tags, walks
// the chunk headers, captures the first 16 bytes of a fmt chunk, passes data
// chunk bytes out as sample results and closes each file with one summary
// result. A byte is accepted every cycle while the request queue has room; a
// result is registered first in the request queue and then in the output register.
// A data byte that ends the file yields two results, a sample and then the
// summary; the QUEUE_DEPTH-entry queue absorbs the bytes that arrive meanwhile.
// The front end handles each byte with one 32-bit counter increment plus compares.
module wav_riff_header_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [7:0]  o_sample_byte,
    output logic        o_chunk_first,
    output logic [2:0]  o_status,
    output logic [15:0] o_channels,
    output logic [31:0] o_sample_rate,
    output logic [31:0] o_byte_rate,
    output logic [15:0] o_block_align,
    output logic [15:0] o_bits_per_sample,
    output logic [31:0] o_data_bytes,
    output logic        o_last
);
    logic          w_push, w_full, w_pop, w_empty;
    wrp_pkg::t_cmd w_cmd_in, w_cmd_out;

    // Front end: parsing and classification.
    wrp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_byte     (i_in_byte),
        .i_end_of_file (i_end_of_file),
        .i_queue_full  (w_full),
        .o_in_ready    (o_in_ready),
        .o_push        (w_push),
        .o_cmd         (w_cmd_in)
    );

    // Request queue decoupling the two sides.
    wrp_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_cmd_out)
    );

    // Back end: result formatting and output register.
    wrp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (w_empty),
        .i_cmd             (w_cmd_out),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_result_kind     (o_result_kind),
        .o_sample_byte     (o_sample_byte),
        .o_chunk_first     (o_chunk_first),
        .o_status          (o_status),
        .o_channels        (o_channels),
        .o_sample_rate     (o_sample_rate),
        .o_byte_rate       (o_byte_rate),
        .o_block_align     (o_block_align),
        .o_bits_per_sample (o_bits_per_sample),
        .o_data_bytes      (o_data_bytes),
        .o_last            (o_last)
    );

endmodule

// ===== src/wrp_checker.sv =====
// Port-level checker for the WAV header parser, bound to the top level.
// Depends on wrp_pkg and wav_riff_header_parser_assert.svh.
`include "wav_riff_header_parser_assert.svh"

module wrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_result_kind,
    input logic [7:0]  o_sample_byte,
    input logic        o_chunk_first,
    input logic [2:0]  o_status,
    input logic [15:0] o_channels,
    input logic [31:0] o_data_bytes,
    input logic        o_last
);
    // A sample result carries no summary information.
    `WRP_ASSERT_NOW(a_sample_clean, i_clk, i_rst_n, o_out_valid && o_result_kind == wrp_pkg::RK_SAMPLE, !o_last && o_status == wrp_pkg::ST_OK && o_channels == '0 && o_data_bytes == '0)

    // A summary closes the run and carries no sample byte.
    `WRP_ASSERT_NOW(a_summary_clean, i_clk, i_rst_n, o_out_valid && o_result_kind == wrp_pkg::RK_SUMMARY, o_last && o_sample_byte == '0 && !o_chunk_first)

    // The status is always one of the defined codes.
    `WRP_ASSERT_NOW(a_status_range, i_clk, i_rst_n, o_out_valid, o_status <= wrp_pkg::ST_NO_DATA)

    // A stalled result stays put.
    `WRP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_result_kind) && $stable(o_sample_byte) && $stable(o_status) && $stable(o_data_bytes))

endmodule

bind wav_riff_header_parser wrp_checker u_wrp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_result_kind (o_result_kind),
    .o_sample_byte (o_sample_byte),
    .o_chunk_first (o_chunk_first),
    .o_status      (o_status),
    .o_channels    (o_channels),
    .o_data_bytes  (o_data_bytes),
    .o_last        (o_last)
);
